// ===== rtl/core/encoder_angle_and_moving_average_speed_macros.svh =====
// Assertion helpers for the encoder angle and speed block.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ENCODER_ANGLE_AND_MOVING_AVERAGE_SPEED_MACROS_SVH
`define ENCODER_ANGLE_AND_MOVING_AVERAGE_SPEED_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define EAMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication.
`define EAMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define EAMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define EAMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/eams_pkg.sv =====
`default_nettype none

package eams_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int WINDOW_DEF     = 16;

    localparam int OFFSET_W    = 21;
    localparam int CPR_W       = 21;
    localparam int GAIN_W      = 32;
    localparam int ANGLE_W     = 16;
    localparam int SUM_W       = 24;
    localparam int SPEED_W     = 32;
    localparam int SPEED_FRAC  = 8;
    localparam int PROD_W      = SUM_W + GAIN_W + 1;
    localparam int FIXED_OUT_W = ANGLE_W + SUM_W + 2 * SPEED_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Output queue depth; it must exceed the number of pipeline stages.
    localparam int FIFO_DEPTH = 8;

    localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);

    localparam logic [CFG_ADDR_W-1:0] REG_COUNT_OFFSET   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_REV = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_GAIN     = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_RPM_GAIN       = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_OMEGA_GAIN     = CFG_ADDR_W'(4);

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_RECIP,
        SU_RESIDUE
    } t_setup_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic int pad8(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

    // Floor of the product over 2^8, clamped to the signed 32-bit range.
    function automatic logic [SPEED_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        logic [PROD_W-SPEED_W:0]  top;
        logic [SPEED_W-1:0]       r;
        q   = p >>> SPEED_FRAC;
        top = q[PROD_W-1:SPEED_W-1];
        if ((&top) || !(|top)) begin
            r = q[SPEED_W-1:0];
        end else if (q[PROD_W-1]) begin
            r = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SPEED_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/encoder_angle_and_moving_average_speed.sv =====
// Throughput: one word per cycle while the input is not held off by the setup or by back-pressure,
// set by a five-stage pipeline drained into an 8-word queue.
// After reset, and after each write of count_offset or counts_per_rev, the serial divider
// forms the modulus reciprocal and offset residue in 2*max(COUNT_BITS+2,21) steps; input
// is held off while it runs. Reset is synchronous, active low, and resets the configuration
// registers and valid bits and clears the previous count, the increment history and the sum.
`default_nettype none

module encoder_angle_and_moving_average_speed #(
    parameter int WINDOW     = eams_pkg::WINDOW_DEF,
    parameter int COUNT_BITS = eams_pkg::COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    // position_count
    input  wire logic [eams_pkg::pad8(COUNT_BITS)-1:0] i_s_tdata,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,

    // absolute_count, electrical_angle, count_increment, window_sum, speed_rpm, speed_elec
    output logic [eams_pkg::pad8(2*COUNT_BITS+1+eams_pkg::FIXED_OUT_W)-1:0] o_m_tdata,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,

    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [eams_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire logic [eams_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    `include "encoder_angle_and_moving_average_speed_macros.svh"

    import eams_pkg::*;

    localparam int CB     = COUNT_BITS;
    localparam int MW     = CB + 1;
    localparam int IW     = CB + 1;
    localparam int CUR_W  = $clog2(WINDOW);
    localparam int CW     = (CB + 1 > CPR_W) ? CB + 1 : CPR_W;
    localparam int EXT_W  = (SUM_W > IW) ? SUM_W : IW;
    localparam int RES_W  = 2 * CB + 1 + FIXED_OUT_W;
    localparam int OUT_W  = pad8(RES_W);
    localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] M_MAX = CW'(1) << CB;

    // Configuration registers
    logic signed [OFFSET_W-1:0] r_offset;
    logic [CPR_W-1:0]           r_cpr;
    logic [GAIN_W-1:0]          r_angle_gain;
    logic [GAIN_W-1:0]          r_rpm_gain;
    logic [GAIN_W-1:0]          r_omega_gain;
    logic                       r_kick;
    logic                       cfg_wr;

    logic [CW-1:0]              cpr_ext;
    logic [MW-1:0]              m_eff;
    logic [CB+1:0]              recip;
    logic [CB-1:0]              offmod;
    logic                       setup_busy;

    logic                       accept;
    logic                       pop;
    logic [OCC_W-1:0]           r_occ;

    // Pipeline registers
    logic                       r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [CB-1:0]              r1_raw;
    logic [MW-1:0]              r2_x;
    logic [CB+1:0]              r2_q0;
    logic [CB-1:0]              r3_s, r4_s, r5_s;
    logic [ANGLE_W-1:0]         r4_angle, r5_angle;
    logic [IW-1:0]              r4_d, r5_d;
    logic [SUM_W-1:0]           r5_sum;

    // Running state
    logic [CB-1:0]              r_prev;
    logic [SUM_W-1:0]           r_sum;
    logic [CUR_W-1:0]           r_cursor;
    logic                       r_filled;

    logic [MW-1:0]              x;
    logic [2*CB+2:0]            prod_q;
    logic [2*CB+2:0]            prod_m;
    logic [CB+1:0]              r0;
    logic [CB+1:0]              r0_sub;
    logic [CB-1:0]              s;
    logic signed [CB+1:0]       diff;
    logic signed [CB+2:0]       two_d;
    logic signed [CB+2:0]       m_s;
    logic signed [CB+1:0]       d_adj;
    logic [CB+31:0]             turn_full;
    logic [IW-1:0]              ring_q;
    logic [IW-1:0]              old_inc;
    logic signed [EXT_W-1:0]    old_ext;
    logic signed [EXT_W-1:0]    d_ext;
    logic [SUM_W-1:0]           sum_next;
    logic [CUR_W-1:0]           cur_next;
    logic [CUR_W-1:0]           ring_raddr;
    logic signed [PROD_W-1:0]   prod_rpm;
    logic signed [PROD_W-1:0]   prod_elec;
    logic [SPEED_W-1:0]         speed_rpm;
    logic [SPEED_W-1:0]         speed_elec;
    logic [RES_W-1:0]           res_word;
    logic [RES_W-1:0]           fifo_data;
    t_fifo_stat                 fifo_stat;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_cpr        <= CPR_RESET;
            r_angle_gain <= '0;
            r_rpm_gain   <= '0;
            r_omega_gain <= '0;
            r_kick       <= 1'b1;
        end else begin
            r_kick <= cfg_wr && ((i_cfg_addr == REG_COUNT_OFFSET) ||
                                 (i_cfg_addr == REG_COUNTS_PER_REV));
            if (cfg_wr) begin
                unique case (i_cfg_addr)
                    REG_COUNT_OFFSET:   r_offset     <= i_cfg_data[OFFSET_W-1:0];
                    REG_COUNTS_PER_REV: r_cpr        <= i_cfg_data[CPR_W-1:0];
                    REG_ANGLE_GAIN:     r_angle_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_RPM_GAIN:       r_rpm_gain   <= i_cfg_data[GAIN_W-1:0];
                    REG_OMEGA_GAIN:     r_omega_gain <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // A zero modulus acts as one; anything above 2^COUNT_BITS is clamped there.
    assign cpr_ext = CW'(r_cpr);
    always_comb begin
        if (r_cpr == '0) begin
            m_eff = MW'(1);
        end else if (cpr_ext > M_MAX) begin
            m_eff = M_MAX[MW-1:0];
        end else begin
            m_eff = cpr_ext[MW-1:0];
        end
    end

    eams_setup #(
        .COUNT_BITS(COUNT_BITS)
    ) u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_kick),
        .i_modulus (m_eff),
        .i_offset  (r_offset),
        .o_recip   (recip),
        .o_residue (offmod),
        .o_busy    (setup_busy)
    );

    // ---------------------------------------------------------------- flow control
    // Credit count covers the words in the pipeline and in the output queue.
    assign o_s_tready = !setup_busy && (r_occ < OCC_W'(FIFO_DEPTH));
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = !fifo_stat.empty;
    assign pop        = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (accept && !pop) begin
            r_occ <= r_occ + OCC_W'(1);
        end else if (pop && !accept) begin
            r_occ <= r_occ - OCC_W'(1);
        end
    end

    // ---------------------------------------------------------------- datapath
    // Modulo by reciprocal: the quotient estimate is low by at most one.
    assign x      = MW'(r1_raw) + MW'(offmod);
    assign prod_q = x * recip;

    assign prod_m = r2_q0 * m_eff;
    assign r0     = (CB + 2)'(r2_x) - prod_m[CB+1:0];
    assign r0_sub = r0 - {1'b0, m_eff};
    assign s      = (r0 >= {1'b0, m_eff}) ? r0_sub[CB-1:0] : r0[CB-1:0];

    // Increment against the previous count, folded once by the modulus.
    assign diff  = $signed({2'b00, r3_s}) - $signed({2'b00, r_prev});
    assign two_d = {diff, 1'b0};
    assign m_s   = $signed({2'b00, m_eff});
    always_comb begin
        if (two_d < -m_s) begin
            d_adj = diff + m_s[CB+1:0];
        end else if (two_d > m_s) begin
            d_adj = diff - m_s[CB+1:0];
        end else begin
            d_adj = diff;
        end
    end

    assign turn_full = r3_s * r_angle_gain;

    // The ring read is registered, so it is addressed at the slot the word in stage 3 will use.
    assign cur_next   = (r_cursor == CUR_W'(WINDOW - 1)) ? '0 : r_cursor + CUR_W'(1);
    assign ring_raddr = r4_v ? cur_next : r_cursor;

    eams_ram #(
        .WIDTH(IW),
        .DEPTH(WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r4_v),
        .i_waddr (r_cursor),
        .i_wdata (r4_d),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    // Slots not yet written since reset hold zero.
    assign old_inc  = r_filled ? ring_q : '0;
    assign old_ext  = EXT_W'($signed(old_inc));
    assign d_ext    = EXT_W'($signed(r4_d));
    assign sum_next = r_sum - old_ext[SUM_W-1:0] + d_ext[SUM_W-1:0];

    assign prod_rpm   = $signed(r5_sum) * $signed({1'b0, r_rpm_gain});
    assign prod_elec  = $signed(r5_sum) * $signed({1'b0, r_omega_gain});
    assign speed_rpm  = scale_sat(prod_rpm);
    assign speed_elec = scale_sat(prod_elec);

    assign res_word = {speed_elec, speed_rpm, r5_sum, r5_d, r5_angle, r5_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5_v     <= 1'b0;
            r_prev   <= '0;
            r_sum    <= '0;
            r_cursor <= '0;
            r_filled <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            if (r3_v) begin
                r_prev <= r3_s;
            end
            if (r4_v) begin
                r_sum    <= sum_next;
                r_cursor <= cur_next;
                if (r_cursor == CUR_W'(WINDOW - 1)) begin
                    r_filled <= 1'b1;
                end
            end
        end
        r1_raw   <= i_s_tdata[CB-1:0];
        r2_x     <= x;
        r2_q0    <= prod_q[2*CB+2:CB+1];
        r3_s     <= s;
        r4_s     <= r3_s;
        r4_angle <= turn_full[31:16];
        r4_d     <= d_adj[IW-1:0];
        r5_s     <= r4_s;
        r5_angle <= r4_angle;
        r5_d     <= r4_d;
        r5_sum   <= sum_next;
    end

    eams_ofifo #(
        .WIDTH(RES_W)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r5_v),
        .i_data  (res_word),
        .i_ready (i_m_tready),
        .o_data  (fifo_data),
        .o_stat  (fifo_stat)
    );

    assign o_m_tdata = OUT_W'(fifo_data);

    // ---------------------------------------------------------------- checks
    `EAMS_ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(FIFO_DEPTH))
    `EAMS_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, r5_v, !fifo_stat.full)
    `EAMS_ASSERT_IMPL(a_residue_range, i_clk, i_rst_n, !setup_busy, MW'(offmod) < m_eff)
    `EAMS_ASSERT_NEXT(a_setup_holds_input, i_clk, i_rst_n, r_kick, !o_s_tready)

endmodule

`default_nettype wire

// ===== rtl/core/eams_ram.sv =====
`default_nettype none

module eams_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/eams_setup.sv =====
`default_nettype none

module eams_setup #(
    parameter int COUNT_BITS = eams_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [COUNT_BITS:0]                 i_modulus,
    input  wire logic signed [eams_pkg::OFFSET_W-1:0] i_offset,
    output logic      [COUNT_BITS+1:0]               o_recip,
    output logic      [COUNT_BITS-1:0]               o_residue,
    output logic                                     o_busy
);

    import eams_pkg::*;

    localparam int DW = (COUNT_BITS + 2 > OFFSET_W) ? COUNT_BITS + 2 : OFFSET_W;
    localparam int SW = $clog2(DW + 1);
    localparam int MW = COUNT_BITS + 1;

    t_setup_state r_state, n_state;

    logic [DW-1:0]         r_dvd, n_dvd;
    logic [DW-1:0]         r_quo, n_quo;
    logic [MW-1:0]         r_rem, n_rem;
    logic [SW-1:0]         r_step, n_step;
    logic [COUNT_BITS+1:0] r_recip, n_recip;
    logic [COUNT_BITS-1:0] r_residue, n_residue;

    logic [MW:0]           sh;
    logic                  ge;
    logic [MW:0]           sh_sub;
    logic [MW-1:0]         rem_step;
    logic [DW-1:0]         quo_step;
    logic                  last;
    logic                  off_neg;
    logic [OFFSET_W-1:0]   off_abs;
    logic [MW-1:0]         rem_comp;

    // One restoring step per cycle: first 2^(COUNT_BITS+1) / modulus, then |offset| mod modulus.
    assign sh       = {r_rem, r_dvd[DW-1]};
    assign ge       = sh >= {1'b0, i_modulus};
    assign sh_sub   = sh - {1'b0, i_modulus};
    assign rem_step = ge ? sh_sub[MW-1:0] : sh[MW-1:0];
    assign quo_step = {r_quo[DW-2:0], ge};
    assign last     = r_step == SW'(1);
    assign off_neg  = i_offset[OFFSET_W-1];
    assign off_abs  = off_neg ? OFFSET_W'(-i_offset) : OFFSET_W'(i_offset);
    assign rem_comp = i_modulus - rem_step;

    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = SU_RECIP;
        end else begin
            unique case (r_state)
                SU_IDLE:    n_state = SU_IDLE;
                SU_RECIP:   n_state = last ? SU_RESIDUE : SU_RECIP;
                SU_RESIDUE: n_state = last ? SU_IDLE : SU_RESIDUE;
                default:    n_state = SU_IDLE;
            endcase
        end
    end

    always_comb begin
        n_dvd     = r_dvd;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_step    = r_step;
        n_recip   = r_recip;
        n_residue = r_residue;
        if (i_start) begin
            n_dvd  = DW'(1) << (COUNT_BITS + 1);
            n_quo  = '0;
            n_rem  = '0;
            n_step = SW'(DW);
        end else begin
            unique case (r_state)
                SU_IDLE: begin
                end
                SU_RECIP: begin
                    n_dvd  = {r_dvd[DW-2:0], 1'b0};
                    n_quo  = quo_step;
                    n_rem  = rem_step;
                    n_step = r_step - SW'(1);
                    if (last) begin
                        n_recip = quo_step[COUNT_BITS+1:0];
                        n_dvd   = DW'(off_abs);
                        n_quo   = '0;
                        n_rem   = '0;
                        n_step  = SW'(DW);
                    end
                end
                SU_RESIDUE: begin
                    n_dvd  = {r_dvd[DW-2:0], 1'b0};
                    n_quo  = quo_step;
                    n_rem  = rem_step;
                    n_step = r_step - SW'(1);
                    if (last) begin
                        // A negative offset folds back into the positive range.
                        if (off_neg && (rem_step != '0)) begin
                            n_residue = rem_comp[COUNT_BITS-1:0];
                        end else begin
                            n_residue = rem_step[COUNT_BITS-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dvd     <= n_dvd;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_recip   <= n_recip;
        r_residue <= n_residue;
    end

    assign o_recip   = r_recip;
    assign o_residue = r_residue;
    assign o_busy    = i_start || (r_state != SU_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/eams_ofifo.sv =====
`default_nettype none

module eams_ofifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_ready,
    output logic      [WIDTH-1:0] o_data,
    output eams_pkg::t_fifo_stat  o_stat
);

    import eams_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             pop;

    assign o_stat.empty = r_cnt == '0;
    assign o_stat.full  = r_cnt == CW'(FIFO_DEPTH);
    assign pop          = i_ready && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import eams_pkg::*;

    localparam int CNT_W        = COUNT_BITS_DEF;
    localparam int WINDOW       = WINDOW_DEF;
    localparam int INC_W        = CNT_W + 1;
    localparam int IN_W         = pad8(CNT_W);
    localparam int OUT_W        = pad8(2 * CNT_W + 1 + FIXED_OUT_W);
    localparam int OUT_FIELDS_W = 2 * CNT_W + 1 + FIXED_OUT_W;
    localparam int LATENCY      = 5;
    localparam longint FULL_TURN = longint'(1) << CNT_W;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = CFG_ADDR_W'(5);
    localparam int                    REG_SPACE       = 1 << CFG_ADDR_W;

    // Fields listed from the top bit down, so a cast of tdata lines up.
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_elec;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic signed [SUM_W-1:0]   window_sum;
        logic signed [INC_W-1:0]   count_increment;
        logic signed [ANGLE_W-1:0] electrical_angle;
        logic        [CNT_W-1:0]   absolute_count;
    } t_speed_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic [IN_W-1:0]       i_s_tdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    encoder_angle_and_moving_average_speed u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // Register shadow and tracker state.
    logic signed [OFFSET_W-1:0] cfg_offset      = '0;
    logic [CPR_W-1:0]           cfg_cpr         = CPR_RESET;
    logic [GAIN_W-1:0]          cfg_angle_gain  = '0;
    logic [GAIN_W-1:0]          cfg_rpm_gain    = '0;
    logic [GAIN_W-1:0]          cfg_omega_gain  = '0;
    logic [CNT_W-1:0]           last_count      = '0;
    logic signed [INC_W-1:0]    inc_ring [WINDOW];
    logic [SUM_W-1:0]           inc_sum         = '0;
    int                         ring_pos        = 0;

    t_speed_word speed_words_due[$];

    int unsigned items_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned reg_writes    = 0;
    int unsigned settings_used = 0;
    int unsigned mismatches    = 0;
    int          ready_hold    = 0;
    bit          feed_gaps_on  = 1'b1;
    bit          drain_stalls_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [SPEED_W-1:0] speed_from_sum(input longint wsum,
                                                         input logic [GAIN_W-1:0] gain);
        longint q;
        q = (wsum * longint'(gain)) >>> SPEED_FRAC;
        if (q > (longint'(1) << 31) - 1) begin
            q = (longint'(1) << 31) - 1;
        end else if (q < -(longint'(1) << 31)) begin
            q = -(longint'(1) << 31);
        end
        return q[SPEED_W-1:0];
    endfunction

    function automatic t_speed_word track_encoder(input logic [CNT_W-1:0] raw);
        longint      modulus;
        longint      wrapped;
        longint      step;
        longint      acc;
        logic [63:0] turn;
        t_speed_word w;
        modulus = longint'(cfg_cpr);
        if (modulus == 0) begin
            modulus = 1;
        end
        if (modulus > FULL_TURN) begin
            modulus = FULL_TURN;
        end
        wrapped = (longint'(raw) + longint'(cfg_offset)) % modulus;
        if (wrapped < 0) begin
            wrapped += modulus;
        end
        turn = 64'(wrapped) * 64'(cfg_angle_gain);
        // One half-revolution correction, even right after a modulus change.
        step = wrapped - longint'(last_count);
        if (2 * step < -modulus) begin
            step += modulus;
        end else if (2 * step > modulus) begin
            step -= modulus;
        end
        last_count = CNT_W'(wrapped);
        acc = longint'(inc_sum) - longint'(inc_ring[ring_pos]) + step;
        inc_sum = SUM_W'(acc);
        inc_ring[ring_pos] = INC_W'(step);
        ring_pos = (ring_pos + 1) % WINDOW;
        w.absolute_count   = CNT_W'(wrapped);
        w.electrical_angle = turn[31:16];
        w.count_increment  = INC_W'(step);
        w.window_sum       = inc_sum;
        w.speed_rpm        = speed_from_sum(longint'($signed(inc_sum)), cfg_rpm_gain);
        w.speed_elec       = speed_from_sum(longint'($signed(inc_sum)), cfg_omega_gain);
        return w;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            if (mismatches < 10) begin
                $display("%0t: word %0d %s expected %0d got %0d",
                         $time, words_checked, name, want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_speed_word got;
        t_speed_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_speed_word'(o_m_tdata[OUT_FIELDS_W-1:0]);
            if (speed_words_due.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected output word %h", $time, o_m_tdata);
                end
                mismatches++;
            end else begin
                want = speed_words_due.pop_front();
                check_field("absolute_count", longint'(want.absolute_count),
                            longint'(got.absolute_count));
                check_field("electrical_angle", longint'(want.electrical_angle),
                            longint'(got.electrical_angle));
                check_field("count_increment", longint'(want.count_increment),
                            longint'(got.count_increment));
                check_field("window_sum", longint'(want.window_sum),
                            longint'(got.window_sum));
                check_field("speed_rpm", longint'(want.speed_rpm),
                            longint'(got.speed_rpm));
                check_field("speed_elec", longint'(want.speed_elec),
                            longint'(got.speed_elec));
            end
            words_checked++;
        end
    end

    // Output side: long holds first, then random stall bursts.
    initial begin
        int burst;
        burst = 0;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                i_m_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_m_tready <= 1'b0;
            end else if (drain_stalls_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 17) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_position(input logic [CNT_W-1:0] pos);
        if (feed_gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'(pos);
        do @(posedge i_clk); while (!o_s_tready);
        speed_words_due.push_back(track_encoder(pos));
        items_sent++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (speed_words_due.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the channel valid so that back-to-back writes need no gap.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (addr)
            REG_COUNT_OFFSET:   cfg_offset     = data[OFFSET_W-1:0];
            REG_COUNTS_PER_REV: cfg_cpr        = data[CPR_W-1:0];
            REG_ANGLE_GAIN:     cfg_angle_gain = data[GAIN_W-1:0];
            REG_RPM_GAIN:       cfg_rpm_gain   = data[GAIN_W-1:0];
            REG_OMEGA_GAIN:     cfg_omega_gain = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic signed [OFFSET_W-1:0] offset,
                                input logic [CPR_W-1:0] cpr,
                                input logic [GAIN_W-1:0] a_gain,
                                input logic [GAIN_W-1:0] r_gain,
                                input logic [GAIN_W-1:0] w_gain);
        drain_results();
        write_reg(REG_COUNT_OFFSET, CFG_DATA_W'(offset));
        write_reg(REG_COUNTS_PER_REV, CFG_DATA_W'(cpr));
        write_reg(REG_ANGLE_GAIN, a_gain);
        write_reg(REG_RPM_GAIN, r_gain);
        write_reg(REG_OMEGA_GAIN, w_gain);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Reset values: a 4096-count modulus and all gains zero; the first
    // increment is taken against a previous count of zero.
    task automatic test_reset_defaults();
        send_position(20'h00000);
        send_position(20'h00001);
        send_position(20'h00FFF);
        send_position(20'h01000);
        send_position(20'h80000);
        send_position(20'hFFFFF);
    endtask

    task automatic test_register_extremes();
        // A zero modulus behaves as one, so every count folds to zero.
        apply_config(-21'sd1048576, 21'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_position(20'hFFFFF);
        // Oversized modulus clamps to a full counter turn; a half-turn gain
        // puts every odd count at exactly minus pi.
        apply_config(21'sd1048575, 21'h1F_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
        send_position(20'h00001);
        send_position(20'h80000);
        send_position(20'hFFFFF);
        send_position(20'h7FFFF);
        send_position(20'h00000);
        // Shrinking the modulus under a large previous count.
        apply_config(21'sd0, 21'd3, 32'h1234_5678, 32'h0001_0000, 32'h0000_8000);
        send_position(20'h55555);
        send_position(20'h00002);
        drain_results();
        for (int a = int'(REG_SPARE_FIRST); a < REG_SPACE; a++) begin
            write_reg(CFG_ADDR_W'(a), $urandom);
        end
        i_cfg_valid <= 1'b0;
        send_position(20'h12345);
    endtask

    task automatic test_speed_saturation();
        apply_config(21'sd0, 21'h10_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (int k = 0; k < 10; k++) begin
            send_position(CNT_W'(k * 500000));
        end
    endtask

    // Output held off while input keeps coming, so the queue fills and the
    // input side has to stall.
    task automatic test_output_backpressure();
        logic [CNT_W-1:0] pos;
        pos = CNT_W'($urandom);
        apply_config(OFFSET_W'($urandom), CPR_W'($urandom_range(1000, 1 << 20)),
                     $urandom, $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18));
        feed_gaps_on = 1'b0;
        ready_hold   = 150;
        for (int k = 0; k < 40; k++) begin
            pos = pos + CNT_W'($urandom_range(0, 300));
            send_position(pos);
        end
    endtask

    task automatic test_random_motion();
        logic signed [OFFSET_W-1:0] offset;
        logic [CPR_W-1:0]           cpr;
        logic [GAIN_W-1:0]          gains [3];
        logic [CNT_W-1:0]           pos;
        int                         speed_step;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 5))
                0:       offset = -21'sd1048576;
                1:       offset = 21'sd1048575;
                2:       offset = '0;
                default: offset = OFFSET_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       cpr = '0;
                1:       cpr = 21'd1;
                2:       cpr = 21'h10_0000;
                3:       cpr = CPR_W'($urandom_range(21'h10_0001, 21'h1F_FFFF));
                4:       cpr = CPR_RESET;
                5:       cpr = CPR_W'($urandom_range(2, 16));
                default: cpr = CPR_W'($urandom_range(1, 1 << 20));
            endcase
            foreach (gains[g]) begin
                case ($urandom_range(0, 4))
                    0:       gains[g] = '0;
                    1:       gains[g] = '1;
                    2:       gains[g] = $urandom;
                    default: gains[g] = $urandom_range(0, 1 << 17);
                endcase
            end
            apply_config(offset, cpr, gains[0], gains[1], gains[2]);
            // The tail of the run goes without any gaps or stalls.
            feed_gaps_on    = (phase < 9) && ($urandom_range(0, 3) != 0);
            drain_stalls_on = (phase < 9) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       speed_step = $urandom_range(0, 64);
                1:       speed_step = $urandom_range(0, 4096);
                2:       speed_step = $urandom_range(0, 1 << 19);
                default: speed_step = $urandom_range(0, 1 << 20);
            endcase
            if ($urandom_range(0, 1) == 1) begin
                speed_step = -speed_step;
            end
            pos = CNT_W'($urandom);
            for (int k = 0; k < 50; k++) begin
                // Mostly steady motion with a little jitter, the rest jumps.
                if ($urandom_range(0, 9) < 7) begin
                    pos = CNT_W'(pos + speed_step + $urandom_range(0, 4) - 2);
                end else begin
                    pos = CNT_W'($urandom);
                end
                send_position(pos);
            end
        end
    endtask

    initial begin
        foreach (inc_ring[i]) begin
            inc_ring[i] = '0;
        end
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_speed_saturation();
        test_output_backpressure();
        test_random_motion();

        drain_results();
        repeat (4 * LATENCY) @(posedge i_clk);
        $display("Sent %0d position words and checked %0d result words; %0d register writes",
                 items_sent, words_checked, reg_writes);
        $display("over %0d settings, with output holds, random gaps and a gap-free tail.",
                 settings_used);
        if (mismatches == 0 && speed_words_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
